[src/ftpe_pkg.sv]
// Shared types, register indexes, reset values and helper functions of the FSK tape encoder.
package ftpe_pkg;

    localparam int unsigned FTPE_QUEUE_DEPTH = 2;

    localparam logic [9:0] SILENCE_US = 10'd2;
    localparam logic [3:0] LAST_DATA_SLOT = 4'd8;

    // Configuration register indexes.
    localparam logic [2:0] REG_MARK_HALF_US   = 3'd0;
    localparam logic [2:0] REG_SPACE_HALF_US  = 3'd1;
    localparam logic [2:0] REG_HEADER_PULSES  = 3'd2;
    localparam logic [2:0] REG_TRAILER_PULSES = 3'd3;
    localparam logic [2:0] REG_BLANK_MS       = 3'd4;
    localparam logic [2:0] REG_MARK_PPB       = 3'd5;
    localparam logic [2:0] REG_SPACE_PPB      = 3'd6;
    localparam logic [2:0] REG_STOP_BITS      = 3'd7;

    // Reset values of the configuration registers.
    localparam logic [9:0]  RST_MARK_HALF_US   = 10'd208;
    localparam logic [9:0]  RST_SPACE_HALF_US  = 10'd417;
    localparam logic [15:0] RST_HEADER_PULSES  = 16'd14400;
    localparam logic [15:0] RST_TRAILER_PULSES = 16'd9600;
    localparam logic [15:0] RST_BLANK_MS       = 16'd2000;
    localparam logic [3:0]  RST_MARK_PPB       = 4'd8;
    localparam logic [3:0]  RST_SPACE_PPB      = 4'd4;
    localparam logic [1:0]  RST_STOP_BITS      = 2'd2;

    typedef enum logic [1:0] {
        CMD_RESTART = 2'd0,
        CMD_TICK    = 2'd1,
        CMD_REQUEST = 2'd2,
        CMD_SKIP    = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [9:0]  mark_half_us;
        logic [9:0]  space_half_us;
        logic [15:0] header_pulses;
        logic [15:0] trailer_pulses;
        logic [15:0] blank_ms;
        logic [3:0]  mark_ppb;
        logic [3:0]  space_ppb;
        logic [1:0]  stop_bits;
    } t_cfg;

    typedef struct packed {
        t_cmd       cmd;
        logic       byte_ready;
        logic [7:0] byte_value;
    } t_cmd_item;

    typedef struct packed {
        logic       pulse_valid;
        logic [9:0] pulse_len;
        logic       byte_taken;
        logic [2:0] phase;
        logic       end_flag;
        logic       exhausted_flag;
    } t_result;

    // Start slot is a space, slots one to eight carry the data LSB first, the rest are stops.
    function automatic logic slot_is_mark(input logic [3:0] slot, input logic [7:0] data);
        logic [3:0] bit_idx;
        bit_idx = slot - 4'd1;
        if (slot == 4'd0) begin
            return 1'b0;
        end else if (slot > LAST_DATA_SLOT) begin
            return 1'b1;
        end else begin
            return data[bit_idx[2:0]];
        end
    endfunction

    // Returns {found, index} of the lowest set bit.
    function automatic logic [4:0] lowest_set(input logic [15:0] mask);
        logic [4:0] res;
        res = 5'd0;
        for (int k = 15; k >= 0; k--) begin
            if (mask[k]) begin
                res = {1'b1, 4'(k)};
            end
        end
        return res;
    endfunction

endpackage

[src/fsk_tape_pulse_encoder_top.sv]
// Top level of the FSK cassette pulse encoder: configuration registers, front queue, back sequencer.
// A result is registered by the back end after its item has passed the command queue.
// Throughput: one item per cycle unless stalled; a request's half-wave comes from one sequencer step.
// The command queue between front and back holds QUEUE_DEPTH items; input stalls when it is full.
// Reset (synchronous, active low): configuration returns to defaults, playback to init phase,
// queue and result register empty.
module fsk_tape_pulse_encoder_top
    import ftpe_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = FTPE_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_func,
    input  logic        i_byte_ready,
    input  logic [7:0]  i_byte_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_pulse_valid,
    output logic [9:0]  o_pulse_len,
    output logic        o_byte_taken,
    output logic [2:0]  o_phase,
    output logic        o_end_flag,
    output logic        o_exhausted_flag,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cfg      r_cfg;
    logic      q_valid;
    t_cmd_item q_item;
    logic      q_pop;
    t_result   result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mark_half_us   <= RST_MARK_HALF_US;
            r_cfg.space_half_us  <= RST_SPACE_HALF_US;
            r_cfg.header_pulses  <= RST_HEADER_PULSES;
            r_cfg.trailer_pulses <= RST_TRAILER_PULSES;
            r_cfg.blank_ms       <= RST_BLANK_MS;
            r_cfg.mark_ppb       <= RST_MARK_PPB;
            r_cfg.space_ppb      <= RST_SPACE_PPB;
            r_cfg.stop_bits      <= RST_STOP_BITS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_MARK_HALF_US:   r_cfg.mark_half_us   <= i_cfg_data[9:0];
                REG_SPACE_HALF_US:  r_cfg.space_half_us  <= i_cfg_data[9:0];
                REG_HEADER_PULSES:  r_cfg.header_pulses  <= i_cfg_data;
                REG_TRAILER_PULSES: r_cfg.trailer_pulses <= i_cfg_data;
                REG_BLANK_MS:       r_cfg.blank_ms       <= i_cfg_data;
                REG_MARK_PPB:       r_cfg.mark_ppb       <= i_cfg_data[3:0];
                REG_SPACE_PPB:      r_cfg.space_ppb      <= i_cfg_data[3:0];
                REG_STOP_BITS:      r_cfg.stop_bits      <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    ftpe_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_func       (i_func),
        .i_byte_ready (i_byte_ready),
        .i_byte_value (i_byte_value),
        .o_q_valid    (q_valid),
        .o_q_item     (q_item),
        .i_q_pop      (q_pop)
    );

    ftpe_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_result  (result)
    );

    assign o_pulse_valid    = result.pulse_valid;
    assign o_pulse_len      = result.pulse_len;
    assign o_byte_taken     = result.byte_taken;
    assign o_phase          = result.phase;
    assign o_end_flag       = result.end_flag;
    assign o_exhausted_flag = result.exhausted_flag;

endmodule

[src/ftpe_front.sv]
// Front end: takes input transfers, classifies the function code and queues the commands.
module ftpe_front
    import ftpe_pkg::*;
#(
    parameter int unsigned DEPTH = FTPE_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_func,
    input  logic       i_byte_ready,
    input  logic [7:0] i_byte_value,
    output logic       o_q_valid,
    output t_cmd_item  o_q_item,
    input  logic       i_q_pop
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_cmd_item        r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;
    logic             push;
    logic             pop;
    t_cmd_item        in_item;

    assign o_stall   = (r_count == CNT_FULL);
    assign o_q_valid = (r_count != '0);
    assign o_q_item  = r_mem[r_rd];
    assign push      = i_valid && !o_stall;
    assign pop       = i_q_pop && o_q_valid;

    always_comb begin
        in_item.cmd        = t_cmd'(i_func);
        in_item.byte_ready = i_byte_ready;
        in_item.byte_value = i_byte_value;
    end

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (push) begin
            n_wr = (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
        end
        if (pop) begin
            n_rd = (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= in_item;
        end
    end

endmodule

[src/ftpe_back.sv]
// Back end: playback sequencer that turns queued commands into half-wave results.
module ftpe_back
    import ftpe_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_q_valid,
    input  t_cmd_item i_q_item,
    output logic      o_q_pop,
    output logic      o_valid,
    input  logic      i_stall,
    output t_result   o_result
);

    typedef enum logic [2:0] {
        PH_INIT    = 3'd0,
        PH_BLANK   = 3'd1,
        PH_HEADER  = 3'd2,
        PH_DATA    = 3'd3,
        PH_TRAILER = 3'd4,
        PH_END     = 3'd5
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [15:0] r_gap, n_gap;
    logic [15:0] r_tone, n_tone;
    logic [3:0]  r_slot, n_slot;
    logic [3:0]  r_pdone, n_pdone;
    logic [7:0]  r_shift, n_shift;
    logic        r_ended, n_ended;
    logic        r_drained, n_drained;
    logic        r_out_valid, n_out_valid;
    t_result     r_out, n_out;

    logic        do_pop;
    logic [9:0]  len;
    logic        took;
    logic [3:0]  last_slot;
    logic [15:0] em_after;
    logic [15:0] em_new;
    logic [4:0]  after_hit;
    logic [4:0]  new_hit;
    logic        cur_mark;
    logic [3:0]  cur_tgt;
    logic [9:0]  cur_len;
    logic [9:0]  after_len;
    logic [9:0]  new_len;
    logic        at_boundary;
    logic [15:0] tone_dec;
    logic [15:0] hdr_left;
    logic [15:0] trl_left;

    assign do_pop  = i_q_valid && (!r_out_valid || !i_stall);
    assign o_q_pop = do_pop;
    assign o_valid = r_out_valid;
    assign o_result = r_out;

    // Slots that would emit at least one half-wave, for the held byte and for an incoming one.
    always_comb begin
        last_slot = LAST_DATA_SLOT + {2'b00, i_cfg.stop_bits};
        for (int k = 0; k < 16; k++) begin
            em_after[k] = (4'(k) <= last_slot) && (4'(k) > r_slot)
                && ((slot_is_mark(4'(k), r_shift) ? i_cfg.mark_ppb : i_cfg.space_ppb) != 4'd0);
            em_new[k] = (4'(k) <= last_slot)
                && ((slot_is_mark(4'(k), i_q_item.byte_value) ? i_cfg.mark_ppb
                                                             : i_cfg.space_ppb) != 4'd0);
        end
        after_hit = lowest_set(em_after);
        new_hit   = lowest_set(em_new);
        cur_mark  = slot_is_mark(r_slot, r_shift);
        cur_tgt   = cur_mark ? i_cfg.mark_ppb : i_cfg.space_ppb;
        cur_len   = cur_mark ? i_cfg.mark_half_us : i_cfg.space_half_us;
        after_len = slot_is_mark(after_hit[3:0], r_shift) ? i_cfg.mark_half_us
                                                          : i_cfg.space_half_us;
        new_len   = slot_is_mark(new_hit[3:0], i_q_item.byte_value) ? i_cfg.mark_half_us
                                                                    : i_cfg.space_half_us;
        at_boundary = (r_slot == 4'd0) && (r_pdone == 4'd0);
        tone_dec  = r_tone - 16'd1;
        hdr_left  = i_cfg.header_pulses - 16'd1;
        trl_left  = i_cfg.trailer_pulses - 16'd1;
    end

    always_comb begin
        n_phase     = r_phase;
        n_gap       = r_gap;
        n_tone      = r_tone;
        n_slot      = r_slot;
        n_pdone     = r_pdone;
        n_shift     = r_shift;
        n_ended     = r_ended;
        n_drained   = r_drained;
        n_out_valid = r_out_valid && i_stall;
        n_out       = r_out;
        len         = 10'd0;
        took        = 1'b0;

        if (do_pop) begin
            unique case (i_q_item.cmd)
                CMD_RESTART: begin
                    n_phase   = PH_INIT;
                    n_ended   = 1'b0;
                    n_drained = 1'b0;
                end
                CMD_TICK: begin
                    if (r_phase == PH_BLANK && r_gap != 16'hFFFF) begin
                        n_gap = r_gap + 16'd1;
                    end
                end
                CMD_SKIP: begin
                    n_ended = 1'b1;
                end
                CMD_REQUEST: begin
                    if (r_ended) begin
                        n_drained = 1'b1;
                    end else begin
                        unique case (r_phase)
                            PH_INIT: begin
                                n_phase = PH_BLANK;
                                n_gap   = 16'd0;
                                len     = SILENCE_US;
                            end
                            PH_BLANK: begin
                                // Once the gap has run out the first leader half-wave
                                // goes out on the same request.
                                if (r_gap >= i_cfg.blank_ms) begin
                                    n_tone  = hdr_left;
                                    n_pdone = 4'd0;
                                    len     = i_cfg.mark_half_us;
                                    if (hdr_left == 16'd0) begin
                                        n_phase = PH_DATA;
                                        n_slot  = 4'd0;
                                    end else begin
                                        n_phase = PH_HEADER;
                                    end
                                end
                            end
                            PH_HEADER: begin
                                n_tone = tone_dec;
                                len    = i_cfg.mark_half_us;
                                if (tone_dec == 16'd0) begin
                                    n_phase = PH_DATA;
                                    n_slot  = 4'd0;
                                    n_pdone = 4'd0;
                                end
                            end
                            PH_DATA: begin
                                if (!at_boundary && r_pdone < cur_tgt) begin
                                    len     = cur_len;
                                    n_pdone = r_pdone + 4'd1;
                                end else if (!at_boundary && after_hit[4]) begin
                                    n_slot  = after_hit[3:0];
                                    n_pdone = 4'd1;
                                    len     = after_len;
                                end else if (i_q_item.byte_ready) begin
                                    // Byte boundary: load the next byte. If every slot of
                                    // it is empty the request ends at the next boundary.
                                    took    = 1'b1;
                                    n_shift = i_q_item.byte_value;
                                    if (new_hit[4]) begin
                                        n_slot  = new_hit[3:0];
                                        n_pdone = 4'd1;
                                        len     = new_len;
                                    end else begin
                                        n_slot  = 4'd0;
                                        n_pdone = 4'd0;
                                    end
                                end else begin
                                    n_slot  = 4'd0;
                                    n_pdone = 4'd0;
                                    n_tone  = trl_left;
                                    len     = i_cfg.mark_half_us;
                                    if (trl_left == 16'd0) begin
                                        n_phase = PH_END;
                                        n_ended = 1'b1;
                                    end else begin
                                        n_phase = PH_TRAILER;
                                    end
                                end
                            end
                            PH_TRAILER: begin
                                n_tone = tone_dec;
                                len    = i_cfg.mark_half_us;
                                if (tone_dec == 16'd0) begin
                                    n_phase = PH_END;
                                    n_ended = 1'b1;
                                end
                            end
                            default: begin
                                n_phase = PH_END;
                                n_ended = 1'b1;
                            end
                        endcase
                    end
                end
            endcase

            n_out_valid          = 1'b1;
            n_out.pulse_valid    = (len != 10'd0);
            n_out.pulse_len      = len;
            n_out.byte_taken     = took;
            n_out.phase          = n_phase;
            n_out.end_flag       = n_ended;
            n_out.exhausted_flag = n_drained;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_INIT;
            r_gap       <= 16'd0;
            r_tone      <= 16'd0;
            r_slot      <= 4'd0;
            r_pdone     <= 4'd0;
            r_shift     <= 8'd0;
            r_ended     <= 1'b0;
            r_drained   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_gap       <= n_gap;
            r_tone      <= n_tone;
            r_slot      <= n_slot;
            r_pdone     <= n_pdone;
            r_shift     <= n_shift;
            r_ended     <= n_ended;
            r_drained   <= n_drained;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

    // The end phase is only reached together with the end flag.
    a_end_implies_ended: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_END) |-> r_ended)
        else $error("end phase without end flag");

    // Requests are only counted as past the end once the end flag is set.
    a_drained_implies_ended: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drained |-> r_ended)
        else $error("exhausted without end");

    // A byte is only consumed by a request that stays in the data phase.
    a_take_in_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.byte_taken) |-> (r_out.phase == PH_DATA))
        else $error("byte taken outside data phase");

    // A result with no half-wave carries a zero length.
    a_len_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.pulse_valid) |-> (r_out.pulse_len == 10'd0))
        else $error("pulse length without pulse");

    // A result left waiting under stall is not overwritten.
    a_hold_under_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled result changed");

endmodule

[sim/tape_pulse_checker.sv]
// Checker for the FSK tape pulse encoder: tracks its state, predicts each result, compares.
`timescale 1ns / 1ps
module tape_pulse_checker
    import ftpe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_func,
    input  logic        i_byte_ready,
    input  logic [7:0]  i_byte_value,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_pulse_valid,
    input  logic [9:0]  i_pulse_len,
    input  logic        i_byte_taken,
    input  logic [2:0]  i_phase,
    input  logic        i_end_flag,
    input  logic        i_exhausted_flag,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    typedef enum logic [2:0] {
        PH_INIT    = 3'd0,
        PH_BLANK   = 3'd1,
        PH_HEADER  = 3'd2,
        PH_DATA    = 3'd3,
        PH_TRAILER = 3'd4,
        PH_END     = 3'd5
    } t_phase;

    t_cfg        cfg;
    t_phase      cur_phase;
    logic [15:0] gap_ms;
    logic [15:0] tone_cnt;
    logic [3:0]  slot;
    logic [3:0]  pulse_cnt;
    logic [7:0]  cur_byte;
    logic        is_ended;
    logic        is_drained;
    t_result     pulse_q[$];
    int          fails = 0;

    // Advances the encoder by one pulse request. Steps that emit nothing run on
    // within the same request until a half-wave comes out or the request stops.
    function automatic logic [9:0] next_halfwave(input logic rdy, input logic [7:0] val,
                                                 output logic took);
        logic [9:0] len;
        logic       is_mark;
        logic [3:0] want;
        logic       done;
        int         guard;
        len = 10'd0;
        took = 1'b0;
        done = 1'b0;
        guard = 0;
        while (!done && guard < 64) begin
            guard++;
            case (cur_phase)
                PH_INIT: begin
                    cur_phase = PH_BLANK;
                    gap_ms = 16'd0;
                    len = SILENCE_US;
                    done = 1'b1;
                end
                PH_BLANK: begin
                    if (gap_ms < cfg.blank_ms) begin
                        done = 1'b1;
                    end else begin
                        cur_phase = PH_HEADER;
                        tone_cnt = cfg.header_pulses;
                        pulse_cnt = 4'd0;
                    end
                end
                PH_HEADER: begin
                    tone_cnt = tone_cnt - 16'd1;
                    if (tone_cnt == 16'd0) begin
                        cur_phase = PH_DATA;
                        slot = 4'd0;
                        pulse_cnt = 4'd0;
                    end
                    len = cfg.mark_half_us;
                    done = 1'b1;
                end
                PH_DATA: begin
                    if (slot == 4'd0 && pulse_cnt == 4'd0 && took) begin
                        // A request never takes two bytes; the next one picks this up.
                        done = 1'b1;
                    end else if (slot == 4'd0 && pulse_cnt == 4'd0 && !rdy) begin
                        cur_phase = PH_TRAILER;
                        tone_cnt = cfg.trailer_pulses;
                        pulse_cnt = 4'd0;
                    end else begin
                        if (slot == 4'd0 && pulse_cnt == 4'd0) begin
                            cur_byte = val;
                            took = 1'b1;
                        end
                        if (slot == 4'd0) begin
                            is_mark = 1'b0;
                        end else if (slot >= 4'd9) begin
                            is_mark = 1'b1;
                        end else begin
                            is_mark = cur_byte[3'(slot - 4'd1)];
                        end
                        want = is_mark ? cfg.mark_ppb : cfg.space_ppb;
                        if (pulse_cnt < want) begin
                            pulse_cnt = pulse_cnt + 4'd1;
                            len = is_mark ? cfg.mark_half_us : cfg.space_half_us;
                            done = 1'b1;
                        end else begin
                            pulse_cnt = 4'd0;
                            slot = slot + 4'd1;
                            if (slot > 4'd8 + 4'(cfg.stop_bits)) begin
                                slot = 4'd0;
                            end
                        end
                    end
                end
                PH_TRAILER: begin
                    tone_cnt = tone_cnt - 16'd1;
                    if (tone_cnt == 16'd0) begin
                        cur_phase = PH_END;
                        is_ended = 1'b1;
                    end
                    len = cfg.mark_half_us;
                    done = 1'b1;
                end
                default: begin
                    cur_phase = PH_END;
                    is_ended = 1'b1;
                    done = 1'b1;
                end
            endcase
        end
        return len;
    endfunction

    task automatic check_field(input string name, input logic [15:0] expv,
                               input logic [15:0] actv);
        if (actv !== expv) begin
            fails++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
        end
    endtask

    always @(posedge i_clk) begin : track
        t_result    exp_r;
        logic [9:0] len;
        logic       took;
        if (!i_rst_n) begin
            cfg.mark_half_us   = RST_MARK_HALF_US;
            cfg.space_half_us  = RST_SPACE_HALF_US;
            cfg.header_pulses  = RST_HEADER_PULSES;
            cfg.trailer_pulses = RST_TRAILER_PULSES;
            cfg.blank_ms       = RST_BLANK_MS;
            cfg.mark_ppb       = RST_MARK_PPB;
            cfg.space_ppb      = RST_SPACE_PPB;
            cfg.stop_bits      = RST_STOP_BITS;
            cur_phase  = PH_INIT;
            gap_ms     = 16'd0;
            tone_cnt   = 16'd0;
            slot       = 4'd0;
            pulse_cnt  = 4'd0;
            cur_byte   = 8'd0;
            is_ended   = 1'b0;
            is_drained = 1'b0;
            pulse_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_MARK_HALF_US:   cfg.mark_half_us   = i_cfg_data[9:0];
                    REG_SPACE_HALF_US:  cfg.space_half_us  = i_cfg_data[9:0];
                    REG_HEADER_PULSES:  cfg.header_pulses  = i_cfg_data;
                    REG_TRAILER_PULSES: cfg.trailer_pulses = i_cfg_data;
                    REG_BLANK_MS:       cfg.blank_ms       = i_cfg_data;
                    REG_MARK_PPB:       cfg.mark_ppb       = i_cfg_data[3:0];
                    REG_SPACE_PPB:      cfg.space_ppb      = i_cfg_data[3:0];
                    REG_STOP_BITS:      cfg.stop_bits      = i_cfg_data[1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                len = 10'd0;
                took = 1'b0;
                case (t_cmd'(i_func))
                    CMD_RESTART: begin
                        cur_phase = PH_INIT;
                        is_ended = 1'b0;
                        is_drained = 1'b0;
                    end
                    CMD_TICK: begin
                        if (cur_phase == PH_BLANK && gap_ms != 16'hFFFF) begin
                            gap_ms = gap_ms + 16'd1;
                        end
                    end
                    CMD_REQUEST: begin
                        if (is_ended) begin
                            is_drained = 1'b1;
                        end else begin
                            len = next_halfwave(i_byte_ready, i_byte_value, took);
                        end
                    end
                    default: is_ended = 1'b1;
                endcase
                exp_r.pulse_valid    = (len != 10'd0);
                exp_r.pulse_len      = len;
                exp_r.byte_taken     = took;
                exp_r.phase          = cur_phase;
                exp_r.end_flag       = is_ended;
                exp_r.exhausted_flag = is_drained;
                pulse_q.push_back(exp_r);
            end
            if (i_out_valid && !i_out_stall) begin
                if (pulse_q.size() == 0) begin
                    fails++;
                    $display("%0t: result transfer with nothing expected, actual pulse_len %0d",
                             $time, i_pulse_len);
                end else begin
                    exp_r = pulse_q.pop_front();
                    check_field("pulse_valid", 16'(exp_r.pulse_valid), 16'(i_pulse_valid));
                    check_field("pulse_len", 16'(exp_r.pulse_len), 16'(i_pulse_len));
                    check_field("byte_taken", 16'(exp_r.byte_taken), 16'(i_byte_taken));
                    check_field("phase", 16'(exp_r.phase), 16'(i_phase));
                    check_field("end_flag", 16'(exp_r.end_flag), 16'(i_end_flag));
                    check_field("exhausted_flag", 16'(exp_r.exhausted_flag),
                                16'(i_exhausted_flag));
                end
            end
        end
        o_fail_count <= fails;
        o_pending <= pulse_q.size();
    end

endmodule

[sim/tb_top.sv]
// Testbench top for the FSK tape pulse encoder: clock, reset, stimulus and the verdict.
`timescale 1ns / 1ps
module tb_top
    import ftpe_pkg::*;
();

    localparam int CYCLE_LIMIT = 500_000;
    localparam int RAND_PHASES = 14;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    t_cmd        in_func = CMD_RESTART;
    logic        in_ready = 1'b0;
    logic [7:0]  in_value = 8'd0;
    logic        out_stall = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [2:0]  cfg_index = REG_MARK_HALF_US;
    logic [15:0] cfg_data = 16'd0;
    logic        in_stall;
    logic        out_valid;
    logic        cfg_ready;
    logic        pulse_valid;
    logic [9:0]  pulse_len;
    logic        byte_taken;
    logic [2:0]  phase;
    logic        end_flag;
    logic        exhausted_flag;
    int          fail_count;
    int          pending;
    bit          idle_on = 1'b1;
    int          cycles = 0;

    fsk_tape_pulse_encoder_top u_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_valid          (in_valid),
        .o_stall          (in_stall),
        .i_func           (in_func),
        .i_byte_ready     (in_ready),
        .i_byte_value     (in_value),
        .o_valid          (out_valid),
        .i_stall          (out_stall),
        .o_pulse_valid    (pulse_valid),
        .o_pulse_len      (pulse_len),
        .o_byte_taken     (byte_taken),
        .o_phase          (phase),
        .o_end_flag       (end_flag),
        .o_exhausted_flag (exhausted_flag),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    tape_pulse_checker u_pulse_chk (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_func           (in_func),
        .i_byte_ready     (in_ready),
        .i_byte_value     (in_value),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_pulse_valid    (pulse_valid),
        .i_pulse_len      (pulse_len),
        .i_byte_taken     (byte_taken),
        .i_phase          (phase),
        .i_end_flag       (end_flag),
        .i_exhausted_flag (exhausted_flag),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // Result side: random stall bursts between free-running stretches.
    initial begin : result_stall
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
                if (idle_on && $urandom_range(0, 9) == 0) begin
                    stall_left = $urandom_range(1, 8);
                end
            end
        end
    end

    // Presents one command and holds it until the encoder takes the transfer.
    task automatic send_cmd(input t_cmd cmd, input logic rdy, input logic [7:0] val);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
        end
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_func  <= cmd;
        in_ready <= rdy;
        in_value <= val;
        do @(posedge clk); while (in_stall);
    endtask

    // Stops input, lets every expected result come out, then lets the pipeline settle.
    task automatic quiesce();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic write_cfg(input t_cfg c);
        write_reg(REG_MARK_HALF_US, 16'(c.mark_half_us));
        write_reg(REG_SPACE_HALF_US, 16'(c.space_half_us));
        write_reg(REG_HEADER_PULSES, c.header_pulses);
        write_reg(REG_TRAILER_PULSES, c.trailer_pulses);
        write_reg(REG_BLANK_MS, c.blank_ms);
        write_reg(REG_MARK_PPB, 16'(c.mark_ppb));
        write_reg(REG_SPACE_PPB, 16'(c.space_ppb));
        write_reg(REG_STOP_BITS, 16'(c.stop_bits));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [9:0] pick_len();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 10'd0;
        if (r == 1) return 10'd1;
        if (r == 2) return 10'd1023;
        return 10'($urandom_range(1, 1023));
    endfunction

    // Tones stay short; a zero count wraps to 65536 and is left by a restart.
    function automatic logic [15:0] pick_tone();
        if ($urandom_range(0, 29) == 0) return 16'd0;
        return 16'($urandom_range(1, 4));
    endfunction

    function automatic logic [3:0] pick_ppb();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 4'd0;
        if (r == 1) return 4'd15;
        return 4'($urandom_range(1, 3));
    endfunction

    function automatic t_cfg pick_cfg(input int p);
        t_cfg c;
        case (p)
            0: c = '{10'd1, 10'd1, 16'd1, 16'd1, 16'd0, 4'd1, 4'd1, 2'd1};
            1: c = '{10'd1023, 10'd1023, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd15, 4'd15, 2'd3};
            2: c = '{10'd1023, 10'd1023, 16'hFFFF, 16'hFFFF, 16'd0, 4'd15, 4'd15, 2'd3};
            3: c = '{10'd1023, 10'd1023, 16'd1, 16'd3, 16'd0, 4'd15, 4'd15, 2'd3};
            // Empty bits and no stop bits: every request at a boundary with a byte ready eats one byte.
            4: c = '{10'd0, 10'd5, 16'd1, 16'd2, 16'd0, 4'd0, 4'd0, 2'd0};
            5: c = '{10'd7, 10'd9, 16'd0, 16'd0, 16'd1, 4'd2, 4'd1, 2'd0};
            default: begin
                c.mark_half_us   = pick_len();
                c.space_half_us  = pick_len();
                c.header_pulses  = pick_tone();
                c.trailer_pulses = pick_tone();
                c.blank_ms       = 16'($urandom_range(0, 3));
                c.mark_ppb       = pick_ppb();
                c.space_ppb      = pick_ppb();
                c.stop_bits      = 2'($urandom_range(0, 3));
            end
        endcase
        return c;
    endfunction

    initial begin : stimulus
        t_cmd       cmd;
        logic [7:0] val;
        int         r;
        int         target;
        int         sent;
        int         miss;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: silence pulse, a tick, a request held in the gap, skip to end, a request past it.
        send_cmd(CMD_REQUEST, 1'b1, 8'h00);
        send_cmd(CMD_TICK, 1'b0, 8'h00);
        send_cmd(CMD_REQUEST, 1'b1, 8'hFF);
        send_cmd(CMD_SKIP, 1'b0, 8'h00);
        send_cmd(CMD_REQUEST, 1'b1, 8'h00);
        quiesce();

        // One byte of all ones through the whole frame, then trailer and end, a request past it and a tick.
        write_cfg(pick_cfg(0));
        send_cmd(CMD_RESTART, 1'b0, 8'h00);
        repeat (12) send_cmd(CMD_REQUEST, 1'b1, 8'hFF);
        send_cmd(CMD_REQUEST, 1'b0, 8'h00);
        send_cmd(CMD_REQUEST, 1'b0, 8'h00);
        send_cmd(CMD_TICK, 1'b1, 8'hFF);

        for (int p = 0; p < RAND_PHASES; p++) begin
            quiesce();
            idle_on = (p < RAND_PHASES - 2);
            write_cfg(pick_cfg(p));
            case (p)
                0: target = 120;
                1: target = 30;
                2: target = 40;
                3: target = 200;
                4: target = 60;
                5: target = 40;
                default: target = 60;
            endcase
            // Odd phases run out of bytes more often so the trailer gets reached.
            miss = (p % 2 == 1) ? 4 : 1;
            send_cmd(CMD_RESTART, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            sent = 0;
            while (sent < target) begin
                r = $urandom_range(0, 199);
                if (r < 2) begin
                    cmd = CMD_RESTART;
                end else if (r < 3) begin
                    cmd = CMD_SKIP;
                end else if (r < 19) begin
                    cmd = CMD_TICK;
                end else begin
                    cmd = CMD_REQUEST;
                end
                r = $urandom_range(0, 9);
                if (r == 0) begin
                    val = 8'h00;
                end else if (r == 1) begin
                    val = 8'hFF;
                end else begin
                    val = 8'($urandom_range(0, 255));
                end
                send_cmd(cmd, ($urandom_range(0, 9) >= miss), val);
                if (cmd != CMD_TICK) begin
                    sent++;
                end
            end
        end
        quiesce();

        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
